// ===== design/dcm_pkg.sv =====
// Shared types and constants for the direct 2D convolution block.
package dcm_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int SUM_WIDTH  = 48;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  // Signed width of an input coordinate as seen through stride and padding.
  localparam int CW         = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] REQ_FEATURE = 2'd0;
  localparam logic [1:0] REQ_WEIGHT  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTERS  = 3'd5;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [3:0]                   filter_index;
    logic [3:0]                   channel_index;
    logic [4:0]                   row;
    logic [4:0]                   col;
    logic signed [DATA_WIDTH-1:0] value;
  } dcm_in_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] conv_sum;
    logic                        status;
    logic [3:0]                  out_filter;
  } dcm_out_t;

  typedef struct packed {
    logic clr;
    logic valid;
    logic zero;
  } dcm_mac_ctl_t;

endpackage

// ===== design/dcm_mac.sv =====
// Shared multiply-accumulate unit: registered product, then 48-bit accumulation.
module dcm_mac
  import dcm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  dcm_mac_ctl_t                 ctl,
  input  logic signed [DATA_WIDTH-1:0] feat,
  input  logic signed [DATA_WIDTH-1:0] wgt,
  output logic signed [SUM_WIDTH-1:0]  acc,
  output logic                         busy
);

  logic                         prod_valid_r, prod_valid_nxt;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PROD_WIDTH-1:0] prod_r;
  logic signed [SUM_WIDTH-1:0]  acc_r;

  assign prod_valid_nxt = ctl.valid;

  // The product is formed on its own so both factors stay signed.
  assign prod = feat * wgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
    end
  end

  // A padded position contributes a zero product.
  always_ff @(posedge clk) begin
    prod_r <= ctl.zero ? '0 : prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_valid_r) begin
      acc_r <= acc_r + {{(SUM_WIDTH-PROD_WIDTH){prod_r[PROD_WIDTH-1]}}, prod_r};
    end
  end

  assign acc  = acc_r;
  assign busy = prod_valid_r;

endmodule

// ===== design/direct_conv2d_mac_top.sv =====
// Top level of the direct 2D convolution block with feature and weight stores.
// Load beats (feature element or weight) are written in the cycle they are
// accepted, so loads can stream at one per cycle while the block is idle. A
// compute beat runs the single multiply-accumulate unit once per channel and
// kernel position; its run time is set by that one MAC and the two registered
// memory and product stages ahead of the accumulator. A compute beat whose
// filter or output coordinate lies outside the grid skips the MAC and returns
// status 1. The result sits in an output register, so a stalled result only
// holds the block when the next result is ready to leave.
module direct_conv2d_mac_top
  import dcm_pkg::*;
#(
  parameter int MAX_SIZE     = 32,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_KERNEL   = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dcm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dcm_out_t              out_data
);

  localparam int FEAT_DEPTH = MAX_CHANNELS * MAX_SIZE * MAX_SIZE;
  localparam int WGT_DEPTH  = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int FAW = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Configuration registers.
  logic [2:0] stride_r, padding_r, kernel_r;
  logic [5:0] in_size_r;
  logic [4:0] channels_r, filters_r;

  // Saturated working values.
  logic [2:0] st, pd, k;
  logic [5:0] n;
  logic [4:0] nc, nf;

  logic [2:0] state_r, state_nxt;
  logic [3:0] f_r, f_nxt;
  logic [4:0] row_r, row_nxt, col_r, col_nxt;
  logic [3:0] ci_r, ci_nxt;
  logic [2:0] s_r, s_nxt, r_r, r_nxt;
  logic signed [CW-1:0] ir_r, ir_nxt, ic_r, ic_nxt;
  logic signed [CW-1:0] ir0_r, ir0_nxt, ic0_r, ic0_nxt;
  logic status_r, status_nxt;
  logic rd_valid_r, rd_valid_nxt, rd_zero_r, rd_zero_nxt;
  logic out_valid_r, out_valid_nxt;
  dcm_out_t out_data_r;

  logic in_acc, out_free, last_pos, in_bounds, grid_ok;
  logic [7:0] row_st, col_st;
  logic [6:0] span, lim;

  logic signed [DATA_WIDTH-1:0] feat_mem [FEAT_DEPTH];
  logic signed [DATA_WIDTH-1:0] wgt_mem  [WGT_DEPTH];
  logic signed [DATA_WIDTH-1:0] feat_rd_r, wgt_rd_r;
  logic           feat_we, wgt_we;
  logic [FAW-1:0] feat_waddr, feat_raddr;
  logic [WAW-1:0] wgt_waddr, wgt_raddr;

  dcm_mac_ctl_t               mac_ctl;
  logic                        mac_clr;
  logic signed [SUM_WIDTH-1:0] mac_acc;
  logic                        mac_busy;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r   <= 3'd1;
      padding_r  <= 3'd0;
      in_size_r  <= 6'd32;
      kernel_r   <= 3'd3;
      channels_r <= 5'd1;
      filters_r  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIDE:   stride_r   <= cfg_wdata[2:0];
        CFG_PADDING:  padding_r  <= cfg_wdata[2:0];
        CFG_IN_SIZE:  in_size_r  <= cfg_wdata;
        CFG_KERNEL:   kernel_r   <= cfg_wdata[2:0];
        CFG_CHANNELS: channels_r <= cfg_wdata[4:0];
        CFG_FILTERS:  filters_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st = (stride_r == 3'd0) ? 3'd1 : stride_r;
    pd = (padding_r == 3'd7) ? 3'd6 : padding_r;
    if (in_size_r == 6'd0)               n = 6'd1;
    else if (32'(in_size_r) > MAX_SIZE)  n = 6'(MAX_SIZE);
    else                                 n = in_size_r;
    if (kernel_r == 3'd0)                k = 3'd1;
    else if (32'(kernel_r) > MAX_KERNEL) k = 3'(MAX_KERNEL);
    else                                 k = kernel_r;
    if (channels_r == 5'd0)                 nc = 5'd1;
    else if (32'(channels_r) > MAX_CHANNELS) nc = 5'(MAX_CHANNELS);
    else                                    nc = channels_r;
    if (filters_r == 5'd0)                nf = 5'd1;
    else if (32'(filters_r) > MAX_FILTERS) nf = 5'(MAX_FILTERS);
    else                                  nf = filters_r;
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Load beats write straight into the stores; out-of-store loads are dropped.
  assign feat_we = in_acc && (in_data.req_type == REQ_FEATURE)
                   && (32'(in_data.channel_index) < MAX_CHANNELS)
                   && (32'(in_data.row) < MAX_SIZE) && (32'(in_data.col) < MAX_SIZE);
  assign wgt_we  = in_acc && (in_data.req_type == REQ_WEIGHT)
                   && (32'(in_data.filter_index) < MAX_FILTERS)
                   && (32'(in_data.channel_index) < MAX_CHANNELS)
                   && (32'(in_data.row) < MAX_KERNEL) && (32'(in_data.col) < MAX_KERNEL);
  assign feat_waddr = FAW'((32'(in_data.channel_index) * MAX_SIZE + 32'(in_data.row))
                           * MAX_SIZE + 32'(in_data.col));
  assign wgt_waddr  = WAW'(((32'(in_data.filter_index) * MAX_CHANNELS
                             + 32'(in_data.channel_index)) * MAX_KERNEL
                            + 32'(in_data.row)) * MAX_KERNEL + 32'(in_data.col));

  assign feat_raddr = FAW'((32'(ci_r) * MAX_SIZE + 32'(ir_r[CW-2:0])) * MAX_SIZE
                           + 32'(ic_r[CW-2:0]));
  assign wgt_raddr  = WAW'(((32'(f_r) * MAX_CHANNELS + 32'(ci_r)) * MAX_KERNEL
                            + 32'(s_r)) * MAX_KERNEL + 32'(r_r));

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feat_waddr] <= in_data.value;
    end
    feat_rd_r <= feat_mem[feat_raddr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= in_data.value;
    end
    wgt_rd_r <= wgt_mem[wgt_raddr];
  end

  // Output row r is on the grid exactly when r * stride <= span - kernel.
  always_comb begin
    row_st  = 8'(row_r) * 8'(st);
    col_st  = 8'(col_r) * 8'(st);
    span    = 7'({pd, 1'b0}) + 7'(n);
    lim     = span - 7'(k);
    grid_ok = (span >= 7'(k)) && (row_st <= 8'(lim)) && (col_st <= 8'(lim))
              && (5'(f_r) < nf);
  end

  assign in_bounds = !ir_r[CW-1] && !ic_r[CW-1]
                     && (ir_r[CW-2:0] < (CW-1)'(n)) && (ic_r[CW-2:0] < (CW-1)'(n));
  assign last_pos  = (r_r == k - 3'd1) && (s_r == k - 3'd1) && ({1'b0, ci_r} == nc - 5'd1);

  always_comb begin
    state_nxt     = state_r;
    f_nxt         = f_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ci_nxt        = ci_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    ir_nxt        = ir_r;
    ic_nxt        = ic_r;
    ir0_nxt       = ir0_r;
    ic0_nxt       = ic0_r;
    status_nxt    = status_r;
    rd_valid_nxt  = 1'b0;
    rd_zero_nxt   = !in_bounds;
    out_valid_nxt = out_valid_r && out_stall;
    mac_clr       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_COMPUTE)) begin
          f_nxt     = in_data.filter_index;
          row_nxt   = in_data.row;
          col_nxt   = in_data.col;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        ci_nxt      = '0;
        s_nxt       = '0;
        r_nxt       = '0;
        ir0_nxt     = $signed({2'b00, row_st}) - $signed({7'd0, pd});
        ic0_nxt     = $signed({2'b00, col_st}) - $signed({7'd0, pd});
        ir_nxt      = ir0_nxt;
        ic_nxt      = ic0_nxt;
        status_nxt  = !grid_ok;
        mac_clr     = 1'b1;
        state_nxt   = grid_ok ? S_RUN : S_DONE;
      end
      S_RUN: begin
        rd_valid_nxt = 1'b1;
        if (r_r != k - 3'd1) begin
          r_nxt  = r_r + 3'd1;
          ic_nxt = ic_r + 10'sd1;
        end else begin
          r_nxt  = '0;
          ic_nxt = ic0_r;
          if (s_r != k - 3'd1) begin
            s_nxt  = s_r + 3'd1;
            ir_nxt = ir_r + 10'sd1;
          end else begin
            s_nxt  = '0;
            ir_nxt = ir0_r;
            ci_nxt = ci_r + 4'd1;
          end
        end
        if (last_pos) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid_r && !mac_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r       <= f_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    ci_r      <= ci_nxt;
    s_r       <= s_nxt;
    r_r       <= r_nxt;
    ir_r      <= ir_nxt;
    ic_r      <= ic_nxt;
    ir0_r     <= ir0_nxt;
    ic0_r     <= ic0_nxt;
    status_r  <= status_nxt;
    rd_zero_r <= rd_zero_nxt;
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r.conv_sum   <= status_r ? '0 : mac_acc;
      out_data_r.status     <= status_r;
      out_data_r.out_filter <= f_r;
    end
  end

  assign mac_ctl = '{clr: mac_clr, valid: rd_valid_r, zero: rd_zero_r};

  dcm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .feat  (feat_rd_r),
    .wgt   (wgt_rd_r),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result beat is only raised when the sequencer finishes an item.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat raised outside the finishing state");

  // Off-grid results carry a zero sum.
  a_off_grid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status) |-> (out_data_r.conv_sum == '0))
    else $error("off-grid result with nonzero sum");

  // Memory read beats reach the MAC only while an item is being summed.
  a_mac_feed: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("MAC fed outside the summing phase");

  // The sequencer never stays in setup: it moves on at the next clock edge.
  a_setup_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |=> (state_r != S_SETUP))
    else $error("setup state held");

endmodule
